// ----- rtl/sdct_pkg.sv -----
// Package for the six-digit countdown timer: shared types, widths,
// seven-segment codes and per-digit limits.
// No dependencies.
package sdct_pkg;

   // Field and bus widths
   localparam int DIGIT_W          = 4;
   localparam int DIGIT_N          = 6;
   localparam int CURSOR_W         = 3;
   localparam int RELOAD_W         = 16;
   localparam int SLOT_W           = 4;
   localparam int SEG_W            = 7;
   localparam int SEL_W            = 6;
   localparam int REQ_DATA_W       = 8;
   localparam int RSP_DATA_W       = 16;

   localparam int SCAN_LAST_DEFAULT = 6;
   localparam logic [RELOAD_W-1:0] COUNT_RELOAD_RESET = 16'd10;

   // HH:MM:SS digits, index 0 is hour tens, index 5 is second units
   typedef logic [DIGIT_N-1:0][DIGIT_W-1:0] digits_type;

   typedef struct packed {
      logic btn_increment;
      logic btn_move;
      logic btn_play;
      logic btn_reset;
   } buttons_type;

   // Timer state after the current tick, handed to the display
   typedef struct packed {
      digits_type digits;
      logic       relay;
      logic       running;
   } timer_status_type;

   // Segment patterns, bit0 = a ... bit6 = g
   localparam logic [SEG_W-1:0] SEG_CODE [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   // Increment limit and borrow refill per digit
   localparam logic [DIGIT_W-1:0] DIGIT_LIMIT [DIGIT_N] = '{
      4'd9, 4'd9, 4'd5, 4'd9, 4'd5, 4'd9
   };
   localparam logic [DIGIT_W-1:0] BORROW_FILL [DIGIT_N] = '{
      4'd0, 4'd9, 4'd5, 4'd9, 4'd5, 4'd9
   };

   localparam logic [CURSOR_W-1:0] CURSOR_LAST = 3'd5;

endpackage

// ----- rtl/six_digit_countdown_timer.sv -----
// Six-digit HH:MM:SS countdown timer with multiplexed seven-segment scan.
//
// req channel: one request per tick, carrying the four button levels.
// rsp channel: one result per request: segment pattern, active-low digit
// select, relay drive and running flag.
// csr channel: writes count_reload, the prescaler terminal value; the
// digits step down once every count_reload + 1 ticks while running.
// csr_ready is always high; write it only while no request is in flight.
//
// The result of an accepted request is in the output register in the next
// cycle. Throughput is one request per cycle while the output register is
// empty or being taken: all per-tick work is one pass of logic between the
// state registers and the output register. req_tready stays high while the
// output register is empty or being taken, so a stalled receiver holds back exactly one result.
//
// Synchronous reset clears the timer (stopped, 00:00:00, cursor 0, relay
// off), sets count_reload to 10, restarts the scan at slot 0 with no digit
// selected, and empties the output register.
// Depends on sdct_pkg, sdct_core and sdct_display.
module six_digit_countdown_timer #(
   parameter int SCAN_LAST = sdct_pkg::SCAN_LAST_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: btn_increment, btn_move, btn_play, btn_reset, zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sdct_pkg::REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: segments[6:0], digit_select[12:7], relay, running, zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sdct_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // count_reload write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sdct_pkg::RELOAD_W-1:0]   csr_data
);
   import sdct_pkg::*;

   logic [RELOAD_W-1:0]   reload_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;
   logic                  accept;
   buttons_type           buttons;
   timer_status_type      status;
   logic [SEG_W-1:0]      segments;
   logic [SEL_W-1:0]      digit_select;

   // Handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign buttons.btn_increment = req_tdata[0];
   assign buttons.btn_move      = req_tdata[1];
   assign buttons.btn_play      = req_tdata[2];
   assign buttons.btn_reset     = req_tdata[3];

   // Prescaler terminal value register
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= COUNT_RELOAD_RESET;
      end else if (csr_valid && csr_ready) begin
         reload_ff <= csr_data;
      end
   end

   sdct_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .buttons      (buttons),
      .count_reload (reload_ff),
      .status       (status)
   );

   sdct_display #(
      .SCAN_LAST (SCAN_LAST)
   ) u_display (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .digits       (status.digits),
      .segments     (segments),
      .digit_select (digit_select)
   );

   // Output register
   always_comb begin
      rsp_data_in = {1'b0, status.running, status.relay, digit_select, segments};
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The relay is never on while the timer is stopped
   a_relay_off_when_stopped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[14] |-> !rsp_data_ff[13])
      else $error("relay on while timer stopped");

   // At most one digit selected
   a_one_digit_selected : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones(~rsp_data_ff[12:7]) <= 1)
      else $error("more than one digit selected");

   // A lit pattern always goes with a selected digit
   a_lit_needs_select : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[6:0] != '0 |-> rsp_data_ff[12:7] != '1)
      else $error("segments lit with no digit selected");

   // An empty output register never blocks requests
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request stalled with empty output register");

endmodule

// ----- rtl/sdct_core.sv -----
// Timer state for the countdown timer: run flag, digits, cursor, button
// edge latches, prescaler and relay. Updated once per accepted request.
// Depends on sdct_pkg.
module sdct_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  sdct_pkg::buttons_type         buttons,
   input  logic [sdct_pkg::RELOAD_W-1:0] count_reload,
   output sdct_pkg::timer_status_type    status
);
   import sdct_pkg::*;

   logic                run_ff,    run_in;
   digits_type          digits_ff, digits_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic                move_latch_ff, move_latch_in;
   logic                incr_latch_ff, incr_latch_in;
   logic [RELOAD_W-1:0] prescale_ff, prescale_in;
   logic                relay_ff,  relay_in;

   logic                was_running;
   logic                borrow;

   // Next state for one tick: play/reset, move, increment, countdown
   always_comb begin
      run_in        = run_ff;
      digits_in     = digits_ff;
      cursor_in     = cursor_ff;
      move_latch_in = move_latch_ff;
      incr_latch_in = incr_latch_ff;
      prescale_in   = prescale_ff;
      relay_in      = relay_ff;
      borrow        = 1'b1;

      // play wins over reset
      if (buttons.btn_play) begin
         run_in = 1'b1;
      end else if (buttons.btn_reset) begin
         run_in        = 1'b0;
         digits_in     = '0;
         cursor_in     = '0;
         move_latch_in = 1'b0;
         prescale_in   = '0;
         relay_in      = 1'b0;
      end

      // setting mode: edge-detected move and increment
      if (!run_in) begin
         if (buttons.btn_move && !move_latch_in) begin
            move_latch_in = 1'b1;
            cursor_in = (cursor_in >= CURSOR_LAST) ? '0 : cursor_in + 3'd1;
         end else if (!buttons.btn_move && move_latch_in) begin
            move_latch_in = 1'b0;
         end
         if (buttons.btn_increment && !incr_latch_in) begin
            incr_latch_in = 1'b1;
            if (cursor_in < 3'(DIGIT_N)) begin
               if (digits_in[cursor_in] >= DIGIT_LIMIT[cursor_in]) begin
                  digits_in[cursor_in] = '0;
               end else begin
                  digits_in[cursor_in] = digits_in[cursor_in] + 4'd1;
               end
            end
         end else if (!buttons.btn_increment && incr_latch_in) begin
            incr_latch_in = 1'b0;
         end
      end

      // countdown: zero check, prescaler, borrow chain
      was_running = run_in;
      if (was_running) begin
         if (digits_in == '0) begin
            run_in        = 1'b0;
            cursor_in     = '0;
            move_latch_in = 1'b0;
            prescale_in   = '0;
            relay_in      = 1'b0;
         end else begin
            relay_in = 1'b1;
         end
         if (prescale_in != count_reload) begin
            prescale_in = prescale_in + 16'd1;
         end else begin
            prescale_in = '0;
            for (int i = DIGIT_N - 1; i >= 1; i--) begin
               if (borrow) begin
                  if (digits_in[i] != '0) begin
                     digits_in[i] = digits_in[i] - 4'd1;
                     borrow       = 1'b0;
                  end else begin
                     digits_in[i] = BORROW_FILL[i];
                  end
               end
            end
            // hour tens stops at zero
            if (borrow && digits_in[0] != '0) begin
               digits_in[0] = digits_in[0] - 4'd1;
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         digits_ff     <= '0;
         cursor_ff     <= '0;
         move_latch_ff <= 1'b0;
         incr_latch_ff <= 1'b0;
         prescale_ff   <= '0;
         relay_ff      <= 1'b0;
      end else if (advance) begin
         run_ff        <= run_in;
         digits_ff     <= digits_in;
         cursor_ff     <= cursor_in;
         move_latch_ff <= move_latch_in;
         incr_latch_ff <= incr_latch_in;
         prescale_ff   <= prescale_in;
         relay_ff      <= relay_in;
      end
   end

   assign status.digits  = digits_in;
   assign status.relay   = relay_in;
   assign status.running = run_in;

endmodule

// ----- rtl/sdct_display.sv -----
// Multiplexed display scan for the countdown timer: scan slot counter,
// held digit select and seven-segment decode of the current digit.
// Depends on sdct_pkg.
module sdct_display #(
   parameter int SCAN_LAST = sdct_pkg::SCAN_LAST_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  sdct_pkg::digits_type       digits,
   output logic [sdct_pkg::SEG_W-1:0] segments,
   output logic [sdct_pkg::SEL_W-1:0] digit_select
);
   import sdct_pkg::*;

   localparam logic [SLOT_W:0] ScanLastExt = (SLOT_W + 1)'(SCAN_LAST);

   logic [SLOT_W-1:0]   slot_ff,   slot_in;
   logic [SEL_W-1:0]    select_ff, select_in;
   logic [SLOT_W:0]     slot_ext;
   logic [SLOT_W:0]     slot_dist;
   logic [CURSOR_W-1:0] shown;
   logic                in_window;

   // Slot s in [SCAN_LAST-5, SCAN_LAST] shows digit SCAN_LAST-s
   always_comb begin
      slot_ext  = {1'b0, slot_ff};
      slot_dist = ScanLastExt - slot_ext;
      shown     = slot_dist[CURSOR_W-1:0];
      in_window = (slot_ext + (SLOT_W + 1)'(DIGIT_N - 1) >= ScanLastExt) &&
                  (slot_ext <= ScanLastExt);
      select_in = select_ff;
      segments  = '0;
      if (in_window) begin
         select_in = ~(SEL_W'(1) << shown);
         if (digits[shown] < 4'd10) begin
            segments = SEG_CODE[digits[shown]];
         end
      end
      slot_in = (slot_ext >= ScanLastExt) ? '0 : slot_ff + 4'd1;
   end

   // Scan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         select_ff <= '1;
      end else if (advance) begin
         slot_ff   <= slot_in;
         select_ff <= select_in;
      end
   end

   assign digit_select = select_in;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the six-digit countdown timer: drives button ticks,
// predicts every display result in a scoreboard class and checks it field by field.
// Depends on sdct_pkg and six_digit_countdown_timer.
`timescale 1ns / 1ps

// One expected display result
typedef struct {
   logic [6:0] segments;
   logic [5:0] digit_select;
   logic       relay;
   logic       running;
} tick_display_type;

// Timer predictor plus queue of display results still to arrive
class timer_scoreboard;
   int          scan_last;
   logic [15:0] reload_value;
   bit          running;
   logic [3:0]  digits [6];
   logic [2:0]  cursor;
   bit          move_held;
   bit          incr_held;
   logic [15:0] prescale;
   logic [3:0]  slot;
   logic [5:0]  select_held;
   bit          relay;
   tick_display_type expected_q[$];
   int          errors;

   function new(int last);
      scan_last    = last;
      reload_value = 16'd10;
      clear_timer();
      incr_held    = 0;
      slot         = '0;
      select_held  = '1;
      errors       = 0;
   endfunction

   function logic [6:0] seg_pattern(logic [3:0] d);
      case (d)
         4'd0: return 7'h3F;
         4'd1: return 7'h06;
         4'd2: return 7'h5B;
         4'd3: return 7'h4F;
         4'd4: return 7'h66;
         4'd5: return 7'h6D;
         4'd6: return 7'h7D;
         4'd7: return 7'h07;
         4'd8: return 7'h7F;
         4'd9: return 7'h6F;
         default: return 7'h00;
      endcase
   endfunction

   // tens of minutes and seconds top out at 5, every other digit at 9
   function logic [3:0] digit_limit(int i);
      return (i == 2 || i == 4) ? 4'd5 : 4'd9;
   endfunction

   function void clear_timer();
      running   = 0;
      foreach (digits[i]) digits[i] = '0;
      cursor    = '0;
      move_held = 0;
      prescale  = '0;
      relay     = 0;
   endfunction

   // borrow chain, hour tens stops at zero
   function void count_down();
      for (int i = 5; i >= 1; i--) begin
         if (digits[i] > 0) begin
            digits[i] = digits[i] - 4'd1;
            return;
         end
         digits[i] = digit_limit(i);
      end
      if (digits[0] > 0) digits[0] = digits[0] - 4'd1;
   endfunction

   function void note_request(sdct_pkg::buttons_type b);
      tick_display_type r;
      bit               all_zero;
      int               k;
      // start has priority over clear
      if (b.btn_play) running = 1;
      else if (b.btn_reset) clear_timer();
      // edge-detected editing while stopped
      if (!running) begin
         if (b.btn_move && !move_held) begin
            move_held = 1;
            cursor    = (cursor >= 5) ? 3'd0 : cursor + 3'd1;
         end else if (!b.btn_move && move_held) begin
            move_held = 0;
         end
         if (b.btn_increment && !incr_held) begin
            incr_held = 1;
            if (cursor < 6) begin
               if (digits[cursor] >= digit_limit(int'(cursor))) digits[cursor] = '0;
               else digits[cursor] = digits[cursor] + 4'd1;
            end
         end else if (!b.btn_increment && incr_held) begin
            incr_held = 0;
         end
      end
      // countdown; a zero timer clears but the prescaler step still runs
      if (running) begin
         all_zero = 1;
         foreach (digits[i]) if (digits[i] != 0) all_zero = 0;
         if (all_zero) clear_timer();
         else relay = 1;
         if (prescale != reload_value) begin
            prescale = prescale + 16'd1;
         end else begin
            prescale = '0;
            count_down();
         end
      end
      // display scan, low slots are blank
      r.segments = '0;
      if (int'(slot) + 5 >= scan_last && int'(slot) <= scan_last) begin
         k           = scan_last - int'(slot);
         select_held = 6'h3F & ~(6'd1 << k);
         r.segments  = seg_pattern(digits[k]);
      end
      slot = (int'(slot) >= scan_last) ? 4'd0 : slot + 4'd1;
      r.digit_select = select_held;
      r.relay        = relay;
      r.running      = running;
      expected_q.push_back(r);
   endfunction

   task report(string msg);
      errors++;
      $display("mismatch %0d: %s", errors, msg);
   endtask

   task check_result(logic [15:0] word);
      tick_display_type want;
      if (expected_q.size() == 0) begin
         report($sformatf("result %h with no request pending", word));
         return;
      end
      want = expected_q.pop_front();
      if (word[6:0] !== want.segments)
         report($sformatf("segments %h, want %h", word[6:0], want.segments));
      if (word[12:7] !== want.digit_select)
         report($sformatf("digit_select %h, want %h", word[12:7], want.digit_select));
      if (word[13] !== want.relay)
         report($sformatf("relay %b, want %b", word[13], want.relay));
      if (word[14] !== want.running)
         report($sformatf("running %b, want %b", word[14], want.running));
   endtask
endclass

module testbench;
   import sdct_pkg::*;

   localparam int SCAN_LAST   = 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 80;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic [RELOAD_W-1:0]   csr_data   = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   wire                   csr_ready;

   timer_scoreboard sb;
   int send_idle;
   int recv_stall;
   int cycles;
   int sent_in_phase;

   six_digit_countdown_timer #(
      .SCAN_LAST(SCAN_LAST)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: check on handshake, random stall
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   function automatic buttons_type pack_buttons(int inc, int mv, int play, int rst);
      buttons_type b;
      b.btn_increment = inc[0];
      b.btn_move      = mv[0];
      b.btn_play      = play[0];
      b.btn_reset     = rst[0];
      return b;
   endfunction

   // one tick request, held until accepted
   task automatic send_request(input buttons_type b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, b.btn_reset, b.btn_play, b.btn_move, b.btn_increment};
      do @(posedge clock); while (!req_tready);
      sb.note_request(b);
      sent_in_phase++;
   endtask

   // press, sometimes hold for a second tick, then release
   task automatic tap(input buttons_type b);
      send_request(b);
      if ($urandom_range(3) == 0) send_request(b);
      send_request(pack_buttons(0, 0, 0, 0));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reload(input logic [RELOAD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.reload_value = value;
   endtask

   // set a time, start, let it run with occasional interference
   task automatic run_episode();
      int r;
      if ($urandom_range(2) != 0) begin
         send_request(pack_buttons($urandom_range(1), $urandom_range(1), 0, 1));
         // half the time head for the seconds so the count can reach zero
         if ($urandom_range(1) == 1)
            repeat ($urandom_range(4, 5)) tap(pack_buttons(0, 1, 0, 0));
      end
      repeat ($urandom_range(1, 4)) begin
         repeat ($urandom_range(0, 2)) tap(pack_buttons(0, 1, 0, 0));
         repeat ($urandom_range(0, 4)) tap(pack_buttons(1, 0, 0, 0));
         if ($urandom_range(7) == 0)
            send_request(pack_buttons($urandom_range(1), $urandom_range(1),
                                      $urandom_range(1), $urandom_range(1)));
      end
      send_request(pack_buttons($urandom_range(1), $urandom_range(1), 1, $urandom_range(1)));
      repeat ($urandom_range(5, 40)) begin
         r = $urandom_range(99);
         if (r < 5)
            send_request(pack_buttons($urandom_range(1), $urandom_range(1), 0, 1));
         else if (r < 8)
            send_request(pack_buttons($urandom_range(1), $urandom_range(1), 1,
                                      $urandom_range(1)));
         else
            send_request(pack_buttons($urandom_range(1), $urandom_range(1), 0, 0));
      end
   endtask

   initial begin
      sb         = new(SCAN_LAST);
      send_idle  = 0;
      recv_stall = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, one decrement per tick
      write_reload(16'd0);
      // all buttons at once: start wins, zero timer clears and borrows to 09:59:59
      send_request(pack_buttons(1, 1, 1, 1));
      send_request(pack_buttons(0, 0, 0, 1));
      // move with a held button, then increment while move is still held
      send_request(pack_buttons(0, 1, 0, 0));
      send_request(pack_buttons(0, 1, 0, 0));
      send_request(pack_buttons(1, 1, 0, 0));
      send_request(pack_buttons(0, 0, 0, 0));
      // minute tens: step past its limit of 5 back to 0, then to 1
      send_request(pack_buttons(0, 1, 0, 0));
      send_request(pack_buttons(0, 0, 0, 0));
      repeat (6) begin
         send_request(pack_buttons(1, 0, 0, 0));
         send_request(pack_buttons(0, 0, 0, 0));
      end
      send_request(pack_buttons(1, 0, 0, 0));
      // run 01:10:00 through a borrow, stop with reset, start from zero
      send_request(pack_buttons(0, 0, 1, 0));
      send_request(pack_buttons(0, 0, 0, 0));
      send_request(pack_buttons(0, 0, 0, 1));
      send_request(pack_buttons(0, 0, 1, 0));
      drain();

      // random part: one reload setting and one idling pattern per phase
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  write_reload(16'd1);     end
            1: begin send_idle = 48; recv_stall = 0;  write_reload(16'hFFFF);  end
            2: begin send_idle = 0;  recv_stall = 48; write_reload(16'd10);    end
            default: begin
               send_idle  = 14;
               recv_stall = 14;
               write_reload(RELOAD_W'($urandom_range(0, 3)));
            end
         endcase
         sent_in_phase = 0;
         while (sent_in_phase < PHASE_ITEMS) run_episode();
         drain();
      end

      if (sb.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/sdct_pkg.sv
rtl/sdct_core.sv
rtl/sdct_display.sv
rtl/six_digit_countdown_timer.sv
sim/testbench.sv
